>>> rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and codes for the scatter-gather list builder: request and
// result structs, configuration register indexes and status codes.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MAXSEG_W = 9;
    localparam int VOFF_W   = 12;
    localparam int USED_W   = 13;
    localparam int SEGIDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGS    = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TOO_MANY    = 2'd1;
    localparam logic [1:0] ST_XLATE_FAULT = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [ADDR_W-1:0]   phys_addr;
        logic                translate_ok;
        logic [VOFF_W-1:0]   virt_page_offset;
        logic [LEN_W-1:0]    remaining_len;
    } sgb_req_t;

    typedef struct packed {
        logic [USED_W-1:0]   consumed_len;
        logic [SEGIDX_W-1:0] segment_index;
        logic [ADDR_W-1:0]   segment_addr;
        logic [LEN_W-1:0]    segment_len;
        logic                opened_new;
        logic [1:0]          status;
    } sgb_rsp_t;

endpackage

>>> rtl/sgb_chunk_cut.sv
// ----------------------------------------------------------------------------
// sgb_chunk_cut
// Cuts one chunk to the page end, the remaining length and the next
// boundary window; also gives the boundary window mask.
// ----------------------------------------------------------------------------
module sgb_chunk_cut import sgb_pkg::*; #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic [VOFF_W-1:0]                    virt_page_offset,
    input  logic [LEN_W-1:0]                     remaining_len,
    input  logic [ADDR_W-1:0]                    phys_addr,
    input  logic [CFG_W-1:0]                     boundary_bytes,
    output logic [$clog2(PAGE_BYTES+1)-1:0]      size,
    output logic [ADDR_W-1:0]                    bmask
);

    localparam int SIZE_W = $clog2(PAGE_BYTES + 1);

    logic [LEN_W-1:0]  page_off;
    logic [LEN_W-1:0]  page_room;
    logic [LEN_W-1:0]  size_a;
    logic [ADDR_W-1:0] bnd_addr;
    logic [ADDR_W-1:0] bnd_room;
    logic [LEN_W-1:0]  size_b;

    always_comb begin
        page_off  = LEN_W'(virt_page_offset) & LEN_W'(PAGE_BYTES - 1);
        page_room = LEN_W'(PAGE_BYTES) - page_off;
        size_a    = (remaining_len < page_room) ? remaining_len : page_room;
        bmask     = ~(boundary_bytes - 32'd1);
        bnd_addr  = (phys_addr + boundary_bytes) & bmask;
        bnd_room  = bnd_addr - phys_addr;
        if ((boundary_bytes != '0) && (size_a > bnd_room)) begin
            size_b = bnd_room;
        end else begin
            size_b = size_a;
        end
        size = SIZE_W'(size_b);
    end

endmodule

>>> rtl/sgb_seg_track.sv
// ----------------------------------------------------------------------------
// sgb_seg_track
// Open segment state and sticky error; decides merge, open or reject for
// each request and forms its result.
// ----------------------------------------------------------------------------
module sgb_seg_track import sgb_pkg::*; #(
    parameter int PAGE_BYTES    = 4096,
    parameter int SEGMENT_SLOTS = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 fire,
    input  sgb_req_t                             req,
    input  logic [$clog2(PAGE_BYTES+1)-1:0]      size,
    input  logic [ADDR_W-1:0]                    bmask,
    input  logic [CFG_W-1:0]                     boundary_bytes,
    input  logic [LEN_W-1:0]                     max_segment_bytes,
    input  logic [MAXSEG_W-1:0]                  max_segments,
    output sgb_rsp_t                             rsp
);

    localparam int IDX_W  = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
    localparam int CMP_W  = MAXSEG_W + 1;
    localparam logic [MAXSEG_W-1:0] SLOTS = MAXSEG_W'(SEGMENT_SLOTS);

    logic [ADDR_W-1:0] last_end_reg, last_end_next;
    logic [ADDR_W-1:0] seg_addr_reg, seg_addr_next;
    logic [LEN_W-1:0]  seg_len_reg,  seg_len_next;
    logic [IDX_W-1:0]  seg_idx_reg,  seg_idx_next;
    logic [1:0]        err_reg,      err_next;

    logic              remain_nz;
    logic              size_zero;
    logic              merge_ok;
    logic              at_limit;
    logic [MAXSEG_W-1:0] limit;
    logic [LEN_W:0]    grown_len;
    logic [LEN_W-1:0]  size_w;
    logic [ADDR_W-1:0] end_addr;
    logic [USED_W-1:0] used;
    logic              opened;

    always_comb begin
        remain_nz = (req.remaining_len != '0);
        size_zero = (size == '0);
        size_w    = LEN_W'(size);
        end_addr  = req.phys_addr + size_w;
        limit     = (max_segments < SLOTS) ? max_segments : SLOTS;
        grown_len = {1'b0, seg_len_reg} + {1'b0, size_w};
        merge_ok  = (req.phys_addr == last_end_reg)
                    && (grown_len <= {1'b0, max_segment_bytes})
                    && ((boundary_bytes == '0)
                        || ((seg_addr_reg & bmask) == (req.phys_addr & bmask)));
        at_limit  = ((CMP_W'(seg_idx_reg) + CMP_W'(1)) >= CMP_W'(limit));

        last_end_next = last_end_reg;
        seg_addr_next = seg_addr_reg;
        seg_len_next  = seg_len_reg;
        seg_idx_next  = seg_idx_reg;
        err_next      = err_reg;
        used          = '0;
        opened        = 1'b0;

        priority if (req.mode) begin
            if (remain_nz && !req.translate_ok) begin
                err_next = ST_XLATE_FAULT;
            end else begin
                err_next      = ST_OK;
                seg_idx_next  = '0;
                seg_addr_next = req.phys_addr;
                seg_len_next  = size_w;
                last_end_next = end_addr;
                used          = USED_W'(size);
                opened        = 1'b1;
            end
        end else if ((err_reg != ST_OK) || !remain_nz) begin
            // nothing consumed, state kept
        end else if (!req.translate_ok) begin
            err_next = ST_XLATE_FAULT;
        end else if (size_zero) begin
            // cut to nothing
        end else if (merge_ok) begin
            seg_len_next  = grown_len[LEN_W-1:0];
            last_end_next = end_addr;
            used          = USED_W'(size);
        end else if (at_limit) begin
            err_next = ST_TOO_MANY;
        end else begin
            seg_idx_next  = seg_idx_reg + IDX_W'(1);
            seg_addr_next = req.phys_addr;
            seg_len_next  = size_w;
            last_end_next = end_addr;
            used          = USED_W'(size);
            opened        = 1'b1;
        end

        rsp.consumed_len  = used;
        rsp.segment_index = SEGIDX_W'(seg_idx_next);
        rsp.segment_addr  = seg_addr_next;
        rsp.segment_len   = seg_len_next;
        rsp.opened_new    = opened;
        rsp.status        = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_end_reg <= '0;
            seg_addr_reg <= '0;
            seg_len_reg  <= '0;
            seg_idx_reg  <= '0;
            err_reg      <= ST_OK;
        end else if (fire) begin
            last_end_reg <= last_end_next;
            seg_addr_reg <= seg_addr_next;
            seg_len_reg  <= seg_len_next;
            seg_idx_reg  <= seg_idx_next;
            err_reg      <= err_next;
        end
    end

endmodule

>>> rtl/dma_scatter_gather_builder.sv
// ----------------------------------------------------------------------------
// dma_scatter_gather_builder
// Builds a DMA segment list from page-bounded chunks, one result per request.
// ----------------------------------------------------------------------------
// Each chunk request is registered at the input, cut and merged into the open
// segment in a single pass, and its result is registered at the output, so a
// result passes the input register and then the result register, and a new
// request is taken every cycle while the result side keeps up. The rate of one
// request per cycle is set by the segment tracking stage, whose open-segment
// state feeds back into itself for each request. Configuration writes take
// effect at once and should be made only while no request is in flight.
module dma_scatter_gather_builder import sgb_pkg::*; #(
    parameter int PAGE_BYTES    = 4096,
    parameter int SEGMENT_SLOTS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sgb_req_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sgb_rsp_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int SIZE_W = $clog2(PAGE_BYTES + 1);

    logic [CFG_W-1:0]    boundary_reg;
    logic [LEN_W-1:0]    max_seg_len_reg;
    logic [MAXSEG_W-1:0] max_segs_reg;

    sgb_req_t            req_reg;
    logic                req_valid_reg;
    sgb_rsp_t            rsp_reg;
    logic                rsp_valid_reg;

    logic                fire;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   bmask;
    sgb_rsp_t            rsp_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boundary_reg    <= '0;
            max_seg_len_reg <= 32'd65536;
            max_segs_reg    <= 9'd16;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BOUNDARY:    boundary_reg    <= cfg_wdata;
                CFG_MAX_SEG_LEN: max_seg_len_reg <= cfg_wdata;
                CFG_MAX_SEGS:    max_segs_reg    <= cfg_wdata[MAXSEG_W-1:0];
                default:         ;
            endcase
        end
    end

    assign fire    = req_valid_reg && (!rsp_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || fire;

    // input request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    sgb_chunk_cut #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_cut (
        .virt_page_offset (req_reg.virt_page_offset),
        .remaining_len    (req_reg.remaining_len),
        .phys_addr        (req_reg.phys_addr),
        .boundary_bytes   (boundary_reg),
        .size             (size),
        .bmask            (bmask)
    );

    sgb_seg_track #(
        .PAGE_BYTES    (PAGE_BYTES),
        .SEGMENT_SLOTS (SEGMENT_SLOTS)
    ) u_track (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fire              (fire),
        .req               (req_reg),
        .size              (size),
        .bmask             (bmask),
        .boundary_bytes    (boundary_reg),
        .max_segment_bytes (max_seg_len_reg),
        .max_segments      (max_segs_reg),
        .rsp               (rsp_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (fire) begin
            rsp_valid_reg <= 1'b1;
        end else if (m_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = rsp_valid_reg;
    assign m_data  = rsp_reg;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_TOO_MANY
                     || m_data.status == ST_XLATE_FAULT))
        else $error("result status is not a defined code");

    a_consume_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.consumed_len != '0)) |-> (m_data.status == ST_OK))
        else $error("bytes consumed while an error is reported");

    a_open_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.opened_new) |-> (m_data.status == ST_OK))
        else $error("segment opened while an error is reported");

    a_no_lost_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending result dropped without being taken");

endmodule
